### src/wsfd_pkg.sv
// Shared types and constants for the weather sensor frame decoder.
`default_nettype none

package wsfd_pkg;

  localparam int FRAME_BITS = 36;
  localparam int POS_W      = $clog2(FRAME_BITS);

  typedef logic [POS_W-1:0] pos_t;

  // Bit positions inside the frame (LSB-first order).
  localparam pos_t POS_ID_LAST     = pos_t'(7);
  localparam pos_t POS_BATTERY     = pos_t'(8);
  localparam pos_t POS_STATUS_LAST = pos_t'(10);
  localparam pos_t POS_BUTTON      = pos_t'(11);
  localparam pos_t POS_TEMP_LAST   = pos_t'(23);
  localparam pos_t POS_HUM_LAST    = pos_t'(31);
  localparam pos_t POS_LAST        = pos_t'(FRAME_BITS - 1);

  localparam logic [3:0]  CHK_INIT      = 4'hF;
  localparam logic [1:0]  STATUS_BAD    = 2'd3;
  localparam logic [31:0] WINDOW_RESET  = 32'd1000000;
  // Duplicate compare ignores the button bit.
  localparam logic [31:0] DUP_MASK      = 32'hFFFF_F7FF;

  // Frame fields packed in frame bit order, bit 0 = id[0].
  typedef struct packed {
    logic [7:0]         humidity;
    logic signed [11:0] temperature;
    logic               button;
    logic [1:0]         status;
    logic               battery;
    logic [7:0]         id;
  } frame_t;

  // One accepted bit as seen by the assembler.
  typedef struct packed {
    logic en;
    logic in_stream;
    logic value;
  } bit_t;

  // Assembler verdict for the current bit.
  typedef struct packed {
    logic   good;
    frame_t frame;
  } asm_out_t;

endpackage

`default_nettype wire

### src/wsfd_in_if.sv
// Bit input channel interface.
`default_nettype none

interface wsfd_in_if;
  logic        valid;
  logic        ready;
  logic        bit_ok;
  logic        bit_contig;
  logic        bit_value;
  logic [31:0] time_us;

  modport source (output valid, output bit_ok, output bit_contig,
                  output bit_value, output time_us, input ready);
  modport sink   (input valid, input bit_ok, input bit_contig,
                  input bit_value, input time_us, output ready);
endinterface

`default_nettype wire

### src/wsfd_out_if.sv
// Decoded frame output channel interface.
`default_nettype none

interface wsfd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         sensor_id;
  logic               battery_flag;
  logic [1:0]         frame_status;
  logic               button_flag;
  logic signed [11:0] temperature_tenths;
  logic [7:0]         humidity_raw;

  modport source (output valid, output sensor_id, output battery_flag,
                  output frame_status, output button_flag,
                  output temperature_tenths, output humidity_raw, input ready);
  modport sink   (input valid, input sensor_id, input battery_flag,
                  input frame_status, input button_flag,
                  input temperature_tenths, input humidity_raw, output ready);
endinterface

`default_nettype wire

### src/weather_sensor_frame_decoder_core.sv
// Top level of the weather sensor frame decoder: assembly, duplicate filter, output.
// Throughput: one bit transfer per cycle; in_ch.ready drops only while the skid holds a result.
// A reported frame is registered into the output register from its last bit's transfer, or into
// the skid register when it queues behind a stalled result.
// A frame is reported at most once every 36 bits, so the skid register is rarely used.
// Reset (rst_n low, synchronous): position 0, checksum 15, fields and last frame cleared,
// suppress window back to 1000000 us, output and skid registers empty.
`default_nettype none

module weather_sensor_frame_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wsfd_in_if.sink          in_ch,
  wsfd_out_if.source       out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  import wsfd_pkg::*;

  // Configuration register.
  logic [31:0] window_r;

  // Last good frame, kept whether reported or suppressed.
  frame_t      prev_frame_r;
  logic [31:0] prev_time_r;

  // Output register plus one skid entry.
  logic        out_valid_r, out_valid_nxt;
  frame_t      out_data_r,  out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  frame_t      skid_data_r,  skid_data_nxt;

  logic        in_fire;
  bit_t        bit_s;
  asm_out_t    asm_s;
  logic [31:0] elapsed;
  logic        is_dup;
  logic        emit;
  logic        out_pop;

  // Only the skid being full blocks input; a waiting result does not.
  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Invalid bits are transfers that touch no state.
  assign bit_s.en        = in_fire && in_ch.bit_ok;
  assign bit_s.in_stream = in_ch.bit_contig;
  assign bit_s.value     = in_ch.bit_value;

  wsfd_assembler u_asm (
    .clk   (clk),
    .rst_n (rst_n),
    .bit_i (bit_s),
    .asm_o (asm_s)
  );

  // Duplicate filter: same frame (button ignored), button clear, inside window.
  assign elapsed = in_ch.time_us - prev_time_r;
  assign is_dup  = (((asm_s.frame ^ prev_frame_r) & DUP_MASK) == '0) &&
                   !asm_s.frame.button && (elapsed < window_r);
  assign emit    = asm_s.good && !is_dup;

  assign out_pop = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // Input is stalled here, so no new result can arrive.
      if (out_pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_pop) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_data_nxt = asm_s.frame;
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = asm_s.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RESET;
      prev_frame_r <= '0;
      prev_time_r  <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (asm_s.good) begin
        prev_frame_r <= asm_s.frame;
        prev_time_r  <= in_ch.time_us;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.sensor_id          = out_data_r.id;
  assign out_ch.battery_flag       = out_data_r.battery;
  assign out_ch.frame_status       = out_data_r.status;
  assign out_ch.button_flag        = out_data_r.button;
  assign out_ch.temperature_tenths = out_data_r.temperature;
  assign out_ch.humidity_raw       = out_data_r.humidity;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result lost while output stalled");

  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status != STATUS_BAD)
    else $error("frame with rejected status reported");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !skid_valid_r && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("reported frame not presented");
`endif

endmodule

`default_nettype wire

### src/wsfd_assembler.sv
// Frame assembler: bit position, field shifters and nibble checksum.
`default_nettype none

module wsfd_assembler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wsfd_pkg::bit_t    bit_i,
  output wsfd_pkg::asm_out_t     asm_o
);
  import wsfd_pkg::*;

  pos_t               pos_r, pos_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic [3:0]         chk_r, chk_nxt;
  frame_t             fr_r, fr_nxt;

  pos_t               pos;
  logic               first;
  logic [3:0]         nib_base, chk_base;
  frame_t             fr_base;

  always_comb begin
    // A gap in mid-frame restarts with this bit as bit 0.
    pos      = (pos_r != '0 && !bit_i.in_stream) ? '0 : pos_r;
    first    = (pos == '0);
    nib_base = first ? '0 : nib_r;
    chk_base = first ? CHK_INIT : chk_r;
    fr_base  = first ? '0 : fr_r;

    fr_nxt = fr_base;
    case (pos) inside
      [pos_t'(0):POS_ID_LAST]:                 fr_nxt.id = {bit_i.value, fr_base.id[7:1]};
      POS_BATTERY:                             fr_nxt.battery = bit_i.value;
      [POS_BATTERY+pos_t'(1):POS_STATUS_LAST]: fr_nxt.status = {bit_i.value, fr_base.status[1]};
      POS_BUTTON:                              fr_nxt.button = bit_i.value;
      [POS_BUTTON+pos_t'(1):POS_TEMP_LAST]:
        fr_nxt.temperature = {bit_i.value, fr_base.temperature[11:1]};
      [POS_TEMP_LAST+pos_t'(1):POS_HUM_LAST]:
        fr_nxt.humidity = {bit_i.value, fr_base.humidity[7:1]};
      default: ;
    endcase

    nib_nxt = {bit_i.value, nib_base[3:1]};
    chk_nxt = (pos[1:0] == 2'b11) ? chk_base - nib_nxt : chk_base;
    pos_nxt = (pos == POS_LAST) ? '0 : pos + pos_t'(1);

    asm_o.good  = bit_i.en && pos == POS_LAST && chk_nxt == '0 &&
                  fr_nxt.status != STATUS_BAD;
    asm_o.frame = fr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      nib_r <= '0;
      chk_r <= CHK_INIT;
      fr_r  <= '0;
    end else if (bit_i.en) begin
      pos_r <= pos_nxt;
      nib_r <= nib_nxt;
      chk_r <= chk_nxt;
      fr_r  <= fr_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("bit position beyond frame end");

  a_good_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    asm_o.good |=> pos_r == '0)
    else $error("good frame did not return position to zero");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !bit_i.en |=> $stable(pos_r))
    else $error("bit position moved without a valid bit");
`endif

endmodule

`default_nettype wire

### tb/tb_weather_sensor_frame_decoder_core.sv
// Testbench for weather_sensor_frame_decoder_core: random bit streams in, decoded frames checked.
`timescale 1ns / 1ps

module tb_weather_sensor_frame_decoder_core;
  import wsfd_pkg::*;

  localparam int ITEM_TARGET   = 1400;  // valid bits to queue before the closing stretch
  localparam int LONG_HOLD     = 400;   // receiver hold-off for the pressure phase
  localparam int WATCHDOG      = 4000;  // cycles without any transfer

  // One bit transfer as offered on the input channel.
  typedef struct packed {
    logic        valid;
    logic        in_stream;
    logic        value;
    logic [31:0] stamp;
  } rx_bit_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  always #6 clk = ~clk;

  wsfd_in_if  bit_ch ();
  wsfd_out_if frame_ch ();

  weather_sensor_frame_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (bit_ch),
    .out_ch     (frame_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Frame assembler and duplicate filter, tracked alongside the block.
  // Updated on every accepted bit transfer; pushes the frames the block owes.
  // ---------------------------------------------------------------------------
  pos_t        asm_pos;
  logic [3:0]  asm_nibble;
  logic [3:0]  asm_check;
  frame_t      asm_fields;
  frame_t      last_good;
  logic [31:0] last_good_time;
  logic [31:0] window_us;
  frame_t      frames_due[$];

  int errors;
  int frames_predicted;
  int frames_checked;
  int bits_accepted;
  int ignored_accepted;
  int stalled_cycles;
  int windows_written;

  task automatic log_error(input string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic assemble_bit(input rx_bit_t b);
    pos_t        p;
    logic        good;
    logic [31:0] elapsed;
    logic [31:0] cur_bits;
    logic [31:0] old_bits;
    if (!b.valid) return;  // demodulator had nothing, state holds

    // A gap mid-frame throws away what was collected; this bit opens a new frame.
    if (asm_pos != '0 && !b.in_stream) asm_pos = '0;
    if (asm_pos == '0) begin
      asm_nibble = '0;
      asm_check  = CHK_INIT;
      asm_fields = '0;
    end
    p = asm_pos;

    // Fields shift in LSB first.
    if (p <= POS_ID_LAST) asm_fields.id = {b.value, asm_fields.id[7:1]};
    else if (p == POS_BATTERY) asm_fields.battery = b.value;
    else if (p <= POS_STATUS_LAST) asm_fields.status = {b.value, asm_fields.status[1]};
    else if (p == POS_BUTTON) asm_fields.button = b.value;
    else if (p <= POS_TEMP_LAST) asm_fields.temperature = {b.value, asm_fields.temperature[11:1]};
    else if (p <= POS_HUM_LAST) asm_fields.humidity = {b.value, asm_fields.humidity[7:1]};

    // Nibble-subtract checksum, one subtraction per completed nibble.
    asm_nibble = {b.value, asm_nibble[3:1]};
    if (p[1:0] == 2'd3) asm_check = asm_check - asm_nibble;

    good    = (p == POS_LAST) && (asm_check == 4'd0) && (asm_fields.status != STATUS_BAD);
    asm_pos = (p == POS_LAST) ? pos_t'(0) : pos_t'(p + 1'b1);

    if (good) begin
      cur_bits = asm_fields;
      old_bits = last_good;
      elapsed  = b.stamp - last_good_time;  // wraps mod 2^32
      // Button is masked from the compare but a pressed button always reports.
      if (((cur_bits & DUP_MASK) != (old_bits & DUP_MASK)) || asm_fields.button ||
          elapsed >= window_us) begin
        frames_due.push_back(asm_fields);
        frames_predicted++;
      end
      // Suppressed or not, a good frame becomes the new reference.
      last_good      = asm_fields;
      last_good_time = b.stamp;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus side: queue of pending bit transfers and a clocked driver.
  // ---------------------------------------------------------------------------
  rx_bit_t send_queue[$];
  rx_bit_t next_bit;
  int      gap_left;
  bit      sender_gaps = 1'b1;
  bit      sink_gaps   = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      bit_ch.valid <= 1'b0;
      gap_left     <= 0;
    end else if (!bit_ch.valid || bit_ch.ready) begin
      // Current transfer (if any) completes at this edge; pick what comes next.
      if (gap_left != 0) begin
        bit_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (send_queue.size() == 0) begin
        bit_ch.valid <= 1'b0;
      end else if (sender_gaps && $urandom_range(0, 7) == 0) begin
        bit_ch.valid <= 1'b0;  // start an idle burst
        gap_left     <= $urandom_range(0, 7);
      end else begin
        next_bit          = send_queue.pop_front();
        bit_ch.valid      <= 1'b1;
        bit_ch.bit_ok     <= next_bit.valid;
        bit_ch.bit_contig <= next_bit.in_stream;
        bit_ch.bit_value  <= next_bit.value;
        bit_ch.time_us    <= next_bit.stamp;
      end
    end
  end

  // Input monitor: every accepted transfer goes through the assembler.
  always @(posedge clk) begin
    if (rst_n && bit_ch.valid && bit_ch.ready) begin
      if (bit_ch.bit_ok) bits_accepted++;
      else ignored_accepted++;
      assemble_bit({bit_ch.bit_ok, bit_ch.bit_contig, bit_ch.bit_value, bit_ch.time_us});
    end
    if (rst_n && bit_ch.valid && !bit_ch.ready) stalled_cycles++;
  end

  // ---------------------------------------------------------------------------
  // Result side: long hold-off in its own counter, short random stalls, checker.
  // ---------------------------------------------------------------------------
  int hold_left;
  int holds_asked;
  int holds_served;
  int stall_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left    <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_ch.ready <= 1'b0;
      stall_left     <= 0;
    end else if (hold_left != 0) begin
      frame_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      frame_ch.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
      frame_ch.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 7);
    end else begin
      frame_ch.ready <= 1'b1;
    end
  end

  frame_t want_frame;

  always @(posedge clk) begin
    if (rst_n && frame_ch.valid && frame_ch.ready) begin
      frames_checked++;
      if (frames_due.size() == 0) begin
        log_error($sformatf("unexpected frame, id %0d", frame_ch.sensor_id));
      end else begin
        want_frame = frames_due.pop_front();
        if (frame_ch.sensor_id !== want_frame.id)
          log_error($sformatf("sensor_id want %0d got %0d", want_frame.id, frame_ch.sensor_id));
        if (frame_ch.battery_flag !== want_frame.battery)
          log_error($sformatf("battery_flag want %0d got %0d", want_frame.battery,
                              frame_ch.battery_flag));
        if (frame_ch.frame_status !== want_frame.status)
          log_error($sformatf("frame_status want %0d got %0d", want_frame.status,
                              frame_ch.frame_status));
        if (frame_ch.button_flag !== want_frame.button)
          log_error($sformatf("button_flag want %0d got %0d", want_frame.button,
                              frame_ch.button_flag));
        if (frame_ch.temperature_tenths !== want_frame.temperature)
          log_error($sformatf("temperature_tenths want %0d got %0d", want_frame.temperature,
                              frame_ch.temperature_tenths));
        if (frame_ch.humidity_raw !== want_frame.humidity)
          log_error($sformatf("humidity_raw want %0d got %0d", want_frame.humidity,
                              frame_ch.humidity_raw));
      end
    end
  end

  // Watchdog: any transfer or register write resets the count.
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((bit_ch.valid && bit_ch.ready) || (frame_ch.valid && frame_ch.ready) || cfg_wr_en)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no transfer for %0d cycles, %0d frames still due",
                 quiet_cycles, frames_due.size());
        $display("[weather_sensor_frame_decoder_core] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream generation. Queue is filled only at the falling edge.
  // ---------------------------------------------------------------------------
  int          bits_queued;
  bit          aligned;        // stream known to sit at frame position 0
  frame_t      gen_last;       // last frame sent as good
  logic [31:0] gen_last_time;

  task automatic queue_bit(input rx_bit_t b);
    send_queue.push_back(b);
    if (b.valid) bits_queued++;
  endtask

  // Append the check nibble that brings the nibble-subtract sum to zero.
  function automatic logic [35:0] with_check(input frame_t f);
    logic [31:0] w;
    logic [3:0]  sum;
    w   = f;
    sum = '0;
    for (int i = 0; i < 8; i++) sum = sum + w[4*i +: 4];
    return {CHK_INIT - sum, w};
  endfunction

  // Push the first nbits of a frame word; invalid bits sprinkled in at junk_pct.
  task automatic push_frame(input logic [35:0] word, input int nbits,
                            input logic [31:0] t_last, input int junk_pct);
    rx_bit_t b;
    for (int i = 0; i < nbits; i++) begin
      while ($urandom_range(0, 99) < junk_pct) begin
        b.valid     = 1'b0;
        b.in_stream = $urandom_range(0, 1);
        b.value     = $urandom_range(0, 1);
        b.stamp     = $urandom;
        queue_bit(b);
      end
      b.valid = 1'b1;
      // First bit: in_stream is a don't-care when aligned, a forced restart otherwise.
      if (i == 0) b.in_stream = aligned ? 1'($urandom_range(0, 1)) : 1'b0;
      else b.in_stream = 1'b1;
      b.value = word[i];
      b.stamp = (i == nbits - 1) ? t_last : $urandom;
      queue_bit(b);
    end
    aligned = (nbits == FRAME_BITS);
  endtask

  task automatic send_good(input frame_t f, input logic [31:0] t_last, input int junk_pct);
    push_frame(with_check(f), FRAME_BITS, t_last, junk_pct);
    gen_last      = f;
    gen_last_time = t_last;
  endtask

  task automatic random_frame();
    frame_t      f;
    logic [31:0] t;
    logic [35:0] w;
    rx_bit_t     r;
    int          kind;
    int          junk;
    kind = $urandom_range(0, 99);
    junk = $urandom_range(0, 1) ? 0 : 8;
    f    = $urandom;
    if (f.status == STATUS_BAD) f.status = $urandom_range(0, 2);
    f.button = ($urandom_range(0, 3) == 0);
    // Often repeat the last good frame to exercise the duplicate filter.
    if (kind < 40) begin
      f        = gen_last;
      f.button = ($urandom_range(0, 3) == 0);
    end
    // Arrival time around the window edges, with wrap.
    case ($urandom_range(0, 5))
      0: t = gen_last_time;
      1: t = gen_last_time + window_us - 1;
      2: t = gen_last_time + window_us;
      3: t = gen_last_time + window_us + 1;
      4: t = $urandom;
      default: t = gen_last_time + $urandom_range(1, 5000);
    endcase
    if (kind < 75) begin
      send_good(f, t, junk);
    end else if (kind < 83) begin
      w = with_check(f);
      w[$urandom_range(0, FRAME_BITS - 1)] ^= 1'b1;  // any single flip breaks the sum
      push_frame(w, FRAME_BITS, t, junk);
    end else if (kind < 89) begin
      f.status = STATUS_BAD;
      push_frame(with_check(f), FRAME_BITS, t, junk);
    end else if (kind < 95) begin
      push_frame(with_check(f), $urandom_range(1, FRAME_BITS - 1), t, junk);
    end else begin
      repeat ($urandom_range(8, 60)) begin
        r.valid     = ($urandom_range(0, 3) != 0);
        r.in_stream = ($urandom_range(0, 3) != 0);
        r.value     = $urandom_range(0, 1);
        r.stamp     = $urandom;
        queue_bit(r);
      end
      aligned = 1'b0;
    end
  endtask

  // Wait until every bit is taken and every due frame has come out, plus margin.
  task automatic drain();
    @(negedge clk);
    while (send_queue.size() != 0 || bit_ch.valid || frames_due.size() != 0 || frame_ch.valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    window_us = value;
    windows_written++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    frame_t      f;
    logic [35:0] w;
    logic [31:0] win;
    int          phase;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    bit_ch.valid      = 1'b0;
    bit_ch.bit_ok     = 1'b0;
    bit_ch.bit_contig = 1'b0;
    bit_ch.bit_value  = 1'b0;
    bit_ch.time_us    = '0;
    frame_ch.ready    = 1'b0;

    // Assembler state as the block leaves reset.
    asm_pos        = '0;
    asm_nibble     = '0;
    asm_check      = CHK_INIT;
    asm_fields     = '0;
    last_good      = '0;
    last_good_time = '0;
    window_us      = WINDOW_RESET;
    gen_last       = '0;
    gen_last_time  = '0;
    aligned        = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset window.
    f = '0;
    send_good(f, 32'd100, 0);                         // equals reset reference: suppressed
    f.id          = 8'hFF;
    f.battery     = 1'b1;
    f.status      = 2'd2;
    f.temperature = 12'h7FF;
    f.humidity    = 8'hFF;
    send_good(f, 32'd200, 0);                         // field maxima
    f.id          = 8'h5A;
    f.battery     = 1'b0;
    f.status      = 2'd1;
    f.temperature = 12'h800;                          // most negative temperature
    f.humidity    = 8'h00;
    send_good(f, 32'd300, 0);
    f.status = STATUS_BAD;
    push_frame(with_check(f), FRAME_BITS, 32'd400, 0); // status 3: dropped
    f.status = 2'd1;
    w = with_check(f);
    w[35] ^= 1'b1;
    push_frame(w, FRAME_BITS, 32'd500, 0);            // bad check nibble
    send_good(f, gen_last_time + WINDOW_RESET - 1, 0); // repeat just inside window
    f.button = 1'b1;
    send_good(f, gen_last_time + 1, 0);               // button forces a report
    f.button = 1'b0;
    send_good(f, gen_last_time + WINDOW_RESET, 0);    // repeat exactly at window
    f.id          = 8'h33;
    f.temperature = 12'hA5C;
    f.humidity    = 8'h81;
    send_good(f, 32'hFFFF_FF00, 30);                  // invalid bits mixed in
    send_good(f, 32'h0000_0010, 0);                   // repeat across time wrap
    push_frame(with_check(f), FRAME_BITS - 1, 32'h15, 0); // cut one bit short
    f.id = 8'hC3;
    send_good(f, 32'h0000_0020, 0);                   // gap restarts the frame
    drain();

    // Back-pressure: long receiver hold while frames stream in without gaps.
    write_window(32'h0);
    sender_gaps = 1'b0;
    holds_asked++;
    for (int i = 0; i < 12; i++) begin
      f = $urandom;
      if (f.status == STATUS_BAD) f.status = 2'd0;
      f.button = 1'b1;
      send_good(f, $urandom, 0);
    end
    drain();
    sender_gaps = 1'b1;

    // Random phases, one window setting each, extremes included.
    phase = 0;
    while (bits_queued < ITEM_TARGET && phase < 12) begin
      case (phase % 6)
        0: win = 32'h0;
        1: win = 32'hFFFF_FFFF;
        2: win = WINDOW_RESET;
        3: win = 32'd1;
        4: win = $urandom;
        default: win = $urandom_range(0, 4000);
      endcase
      write_window(win);
      repeat (3) random_frame();
      drain();
      phase++;
    end

    // Closing stretch without any idling.
    sender_gaps = 1'b0;
    sink_gaps   = 1'b0;
    write_window($urandom_range(0, 3000));
    repeat (6) random_frame();
    drain();

    $display("run: %0d bit transfers (%0d ignored invalid), %0d frames checked, %0d windows",
             bits_accepted, ignored_accepted, frames_checked, windows_written);
    $display("%0d frames predicted; input held off by output back-pressure for %0d cycles",
             frames_predicted, stalled_cycles);
    if (errors == 0) begin
      $display("[weather_sensor_frame_decoder_core] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[weather_sensor_frame_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
